@@ sv/pps_pkg.sv @@
// shared types, constants and state codes for the ping-pong delay with soft clip
// no dependencies; imported by every module of the block
package pps_pkg;

  localparam int DEPTH_DEF = 16384;

  // knee and span of the soft clip in q16.15, clamp level as an integer sample
  localparam logic [31:0] KNEE_Q15  = 32'd851968000;
  localparam logic [32:0] SPAN_Q15  = 33'd221741056;
  localparam logic [12:0] SPAN_INT  = 13'd6767;
  localparam logic [14:0] CLAMP_MAG = 15'd32767;
  // ceil(2^33 / 255), exact floor division by 255 for 25-bit products
  localparam logic [25:0] RECIP_255 = 26'd33686019;
  localparam logic [5:0]  STEPS_CURVE = 6'd28;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FEEDBACK = 2'd0;
  localparam logic [1:0] REG_LENGTH   = 2'd1;
  localparam logic [1:0] REG_ENABLE   = 2'd2;
  localparam logic [1:0] REG_DRIVE    = 2'd3;

  typedef struct packed {
    logic signed [31:0] send_left;
    logic signed [31:0] send_right;
  } pps_send_t;

  typedef struct packed {
    logic signed [15:0] wet_left;
    logic signed [15:0] wet_right;
  } pps_wet_t;

  // per-frame strobes from the sequencer to each lane
  typedef struct packed {
    logic rd;
    logic rd_vld;
    logic wr;
    logic start;
    logic ack;
  } pps_lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_PUSH
  } pps_state_t;

  typedef enum logic [3:0] {
    LN_IDLE,
    LN_SCALE,
    LN_RECIP,
    LN_DRIVE,
    LN_KNEE,
    LN_BEND,
    LN_LOADB,
    LN_CURVE,
    LN_DONE
  } pps_lane_state_t;

endpackage

@@ sv/pps_div.sv @@
// restoring divider, one quotient bit per cycle
// uses pps_pkg; caller guarantees the initial remainder is below the divisor
module pps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] rem_init,
  input  logic [31:0] low_bits,
  input  logic [32:0] den,
  input  logic [5:0]  steps,
  output logic        done,
  output logic [31:0] quo
);
  import pps_pkg::*;

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] low_r, quo_r, quo_nxt;
  logic [32:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [33:0] trial;

  always_comb begin
    trial = {rem_r, low_r[31]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = 33'(trial - {1'b0, den_r});
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = trial[32:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      low_r <= low_bits;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ sv/pps_lane.sv @@
// one channel: delay line memory, feedback write-back and drive / soft clip
// uses pps_pkg and pps_div
module pps_lane #(
  parameter int DEPTH = pps_pkg::DEPTH_DEF,
  parameter int AW    = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pps_pkg::pps_lane_ctl_t ctl,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic signed [31:0]    send,
  input  logic signed [15:0]    other,
  input  logic [7:0]            feedback,
  input  logic [7:0]            drive,
  output logic signed [15:0]    delayed,
  output logic                  done,
  output logic signed [15:0]    wet
);
  import pps_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] q_r;
  logic        vld_r;

  pps_lane_state_t st_r, st_nxt;
  logic        neg_r;
  logic [14:0] mag_r;
  logic [44:0] prod_r;
  logic [50:0] recip_r;
  logic [31:0] drv_r;
  logic [31:0] over_r;
  logic [31:0] z_r;

  logic        div_start, div_done;
  logic [32:0] div_rem, div_den;
  logic [31:0] div_low, div_quo;
  logic [5:0]  div_steps;

  logic signed [16:0] in_int;
  logic signed [24:0] fb_prod;
  logic signed [17:0] fb_sum;
  logic signed [15:0] fb_val;
  logic [9:0]         gain;
  logic [14:0]        mag_in;
  logic [24:0]        drv_rem;

  always_ff @(posedge clk) begin
    if (ctl.wr) mem[wr_addr] <= fb_val;
    if (ctl.rd) begin
      q_r   <= mem[rd_addr];
      vld_r <= ctl.rd_vld;
    end
  end

  // entries past the fill count have never been written and read as zero
  assign delayed = vld_r ? $signed(q_r) : 16'sd0;

  always_comb begin
    in_int  = 17'(send >>> 15);
    fb_prod = 25'(other) * $signed({17'd0, feedback});
    fb_sum  = 18'(in_int) + 18'(fb_prod >>> 8);
    if (fb_sum > 18'sd32767)       fb_val = 16'sd32767;
    else if (fb_sum < -18'sd32768) fb_val = -16'sd32768;
    else                           fb_val = fb_sum[15:0];
  end

  always_comb begin
    gain = 10'd255 + {1'b0, drive, 1'b0} + {2'd0, drive};
    if (!delayed[15])                mag_in = delayed[14:0];
    else if (delayed == -16'sd32768) mag_in = CLAMP_MAG;
    else                             mag_in = 15'(-delayed);
    // remainder of the gain product by 255, always below 255
    drv_rem = 25'(prod_r[24:0] - 25'(recip_r[50:33]) * 25'd255);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LN_IDLE:  if (ctl.start) st_nxt = (drive == 8'd0) ? LN_DONE : LN_SCALE;
      LN_SCALE: st_nxt = LN_RECIP;
      LN_RECIP: st_nxt = LN_DRIVE;
      LN_DRIVE: st_nxt = LN_KNEE;
      LN_KNEE:  st_nxt = (drv_r > KNEE_Q15) ? LN_BEND : LN_DONE;
      LN_BEND:  st_nxt = LN_LOADB;
      LN_LOADB: st_nxt = LN_CURVE;
      LN_CURVE: if (div_done) st_nxt = LN_DONE;
      LN_DONE:  if (ctl.ack) st_nxt = LN_IDLE;
      default:  st_nxt = LN_IDLE;
    endcase
  end

  always_comb begin
    div_start = (st_r == LN_LOADB);
    div_rem   = 33'(prod_r[44:13]);
    div_low   = {prod_r[12:0], 19'd0};
    div_den   = {1'b0, over_r} + SPAN_Q15;
    div_steps = STEPS_CURVE;
    done      = (st_r == LN_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= LN_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      LN_IDLE: if (ctl.start) begin
        neg_r <= delayed[15];
        mag_r <= mag_in;
        z_r   <= {2'd0, mag_in, 15'd0};
      end
      LN_SCALE: prod_r <= {20'd0, 25'(mag_r) * 25'(gain)};
      LN_RECIP: recip_r <= 51'(prod_r[24:0]) * 51'(RECIP_255);
      // (q*255 + r) * 2^15 / 255 is approximated by q * 2^15 + r * 128 + floor(r / 2)
      LN_DRIVE: drv_r <= {recip_r[49:33], drv_rem[7:0], drv_rem[7:1]};
      LN_KNEE: begin
        over_r <= drv_r - KNEE_Q15;
        z_r    <= drv_r;
      end
      LN_BEND:  prod_r <= 45'(over_r) * 45'(SPAN_INT);
      LN_CURVE: if (div_done) z_r <= KNEE_Q15 + div_quo;
      default: ;
    endcase
  end

  pps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low_bits (div_low),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  // floor of the q16.15 value; magnitude never exceeds 32767 here
  assign wet = neg_r ? -$signed(16'((z_r + 32'd32767) >> 15)) : $signed(16'(z_r >> 15));

endmodule

@@ sv/ping_pong_delay_soft_clip.sv @@
// top level: frame sequencer, position and fill count, config registers, output merge
// uses pps_pkg and pps_lane
//
//  channel  handshake          payload          direction
//  in       in_valid/in_ready  in_data (send)   into block
//  out      out_valid/out_ready out_data (wet)  out of block
//  cfg      psel/penable/pwrite pwdata/prdata   apb, pready tied high
//
// a running frame does a memory read, then write-back; with drive nonzero the lanes
// then apply the drive gain by reciprocal multiply and, above the knee, a 28-step
// divide for the soft clip; lanes run side by side
// a frame with the delay stopped goes straight to the push state and skips the lanes
// the next transfer is taken only once the result is loaded
// rst_n is synchronous; the lines are not swept, a fill count marks written entries
// a new frame is taken while the previous result still waits in the output register
module ping_pong_delay_soft_clip #(
  parameter int DELAY_DEPTH = pps_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pps_pkg::pps_send_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pps_pkg::pps_wet_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pps_pkg::*;

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int LW = AW + 1;

  logic [7:0]  feedback_r, drive_r;
  logic [14:0] length_r;
  logic        enable_r;

  pps_state_t    st_r, st_nxt;
  pps_lane_ctl_t ctl;
  logic [AW-1:0] pos_r, addr_r, rd_addr;
  logic [LW-1:0] hwm_r, len_eff, pos_inc;
  logic          run, run_r, accept, push;
  pps_send_t     send_r;
  pps_wet_t      out_r;
  logic          out_valid_r;

  logic signed [15:0] dly_lt, dly_rt, wet_lt, wet_rt;
  logic               done_lt, done_rt;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feedback_r <= '0;
      length_r   <= '0;
      enable_r   <= 1'b0;
      drive_r    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FEEDBACK: feedback_r <= pwdata[7:0];
        REG_LENGTH:   length_r   <= pwdata[14:0];
        REG_ENABLE:   enable_r   <= pwdata[0];
        REG_DRIVE:    drive_r    <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FEEDBACK: prdata = {24'd0, feedback_r};
      REG_LENGTH:   prdata = {17'd0, length_r};
      REG_ENABLE:   prdata = {31'd0, enable_r};
      REG_DRIVE:    prdata = {24'd0, drive_r};
    endcase
  end

  always_comb begin
    len_eff = (int'(length_r) > DELAY_DEPTH) ? LW'(DELAY_DEPTH) : LW'(length_r);
    run     = enable_r && (len_eff != '0);
    rd_addr = (LW'(pos_r) >= len_eff) ? '0 : pos_r;
    pos_inc = LW'(addr_r) + LW'(1);
    accept  = in_valid && in_ready;
    push    = (st_r == ST_PUSH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = run ? ST_LOAD : ST_PUSH;
      ST_LOAD: st_nxt = ST_CALC;
      ST_CALC: if (done_lt && done_rt) st_nxt = ST_PUSH;
      ST_PUSH: if (push) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (st_r == ST_IDLE);
    ctl.rd     = accept && run;
    ctl.rd_vld = LW'(rd_addr) < hwm_r;
    ctl.wr     = (st_r == ST_LOAD);
    ctl.start  = (st_r == ST_LOAD);
    ctl.ack    = push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pos_r       <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ctl.wr) begin
        pos_r <= (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
        if (LW'(addr_r) == hwm_r) hwm_r <= hwm_r + LW'(1);
      end
      if (push)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      send_r <= in_data;
      run_r  <= run;
      addr_r <= rd_addr;
    end
    // merge both lanes into one result transfer
    if (push) begin
      out_r.wet_left  <= run_r ? wet_lt : 16'sd0;
      out_r.wet_right <= run_r ? wet_rt : 16'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pps_lane #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (addr_r),
    .send     (send_r.send_left),
    .other    (dly_rt),
    .feedback (feedback_r),
    .drive    (drive_r),
    .delayed  (dly_lt),
    .done     (done_lt),
    .wet      (wet_lt)
  );

  pps_lane #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (addr_r),
    .send     (send_r.send_right),
    .other    (dly_lt),
    .feedback (feedback_r),
    .drive    (drive_r),
    .delayed  (dly_rt),
    .done     (done_rt),
    .wet      (wet_rt)
  );

endmodule
